// ===== rtl/core/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Cascade PID differential drive: shared package
// Types, register indexes, fixed constants, controller encodings and the
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_REGS  = 8;

  typedef logic        [30:0] gain_t;
  typedef logic signed [31:0] q_t;

  typedef enum logic [2:0] {
    REG_POS_KP        = 3'd0,
    REG_POS_KI_DT     = 3'd1,
    REG_POS_KD_INV_DT = 3'd2,
    REG_VEL_KP        = 3'd3,
    REG_VEL_KI_DT     = 3'd4,
    REG_VEL_KD_INV_DT = 3'd5,
    REG_BASE_VELOCITY = 3'd6,
    REG_VEL_LIMIT     = 3'd7
  } reg_idx_t;

  localparam gain_t BASE_VELOCITY_RESET = 31'd65536;
  localparam gain_t VEL_LIMIT_RESET     = 31'd655360;

  localparam q_t INTEGRAL_BOUND = 32'sd655360;
  localparam q_t TARGET_OFFSET  = 32'sd0;
  localparam logic signed [16:0] TICKS_PER_SECOND = 17'sd32;

  localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;

  typedef enum logic [1:0] {
    LOOP_OUTER = 2'd0,
    LOOP_LEFT  = 2'd1,
    LOOP_RIGHT = 2'd2
  } loop_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_A    = 3'd2,
    PH_B    = 3'd3,
    PH_C    = 3'd4,
    PH_D    = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_PRE  = 4'd1,
    ST_OA   = 4'd2,
    ST_OB   = 4'd3,
    ST_OC   = 4'd4,
    ST_OD   = 4'd5,
    ST_LA   = 4'd6,
    ST_LB   = 4'd7,
    ST_LC   = 4'd8,
    ST_LD   = 4'd9,
    ST_RA   = 4'd10,
    ST_RB   = 4'd11,
    ST_RC   = 4'd12,
    ST_RD   = 4'd13
  } state_t;

  typedef struct packed {
    logic   load;
    phase_t phase;
    loop_t  loop;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic signed [63:0] sx64(input q_t v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic q_t sat32(input logic signed [63:0] v);
    q_t r;
    if (v > Q_MAX64) begin
      r = 32'sh7FFFFFFF;
    end else if (v < Q_MIN64) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic gain_t clamp_vel(input logic signed [63:0] v, input gain_t hi);
    gain_t r;
    if (v < 64'sd0) begin
      r = '0;
    end else if (v > $signed({33'b0, hi})) begin
      r = hi;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cpd_if.sv =====
// ----------------------------------------------------------------------------
// Cascade PID differential drive: channel interfaces
// Valid/ready channels for the sensor items and the drive items.
// ----------------------------------------------------------------------------
interface cpd_in_if;
  logic          valid;
  logic          ready;
  cpd_pkg::q_t   line_offset;
  cpd_pkg::q_t   left_angle;
  cpd_pkg::q_t   right_angle;

  modport source (output valid, output line_offset, output left_angle,
                  output right_angle, input ready);
  modport sink (input valid, input line_offset, input left_angle,
                input right_angle, output ready);
endinterface

interface cpd_out_if;
  logic          valid;
  logic          ready;
  cpd_pkg::gain_t left_drive;
  cpd_pkg::gain_t right_drive;

  modport source (output valid, output left_drive, output right_drive, input ready);
  modport sink (input valid, input left_drive, input right_drive, output ready);
endinterface

// ===== rtl/core/cascade_pid_differential_drive_top.sv =====
// ----------------------------------------------------------------------------
// Cascade PID differential drive: top level
// Outer line-position PID feeding two wheel velocity PIDs, one tick per item.
//
//   Channel   Direction  Payload                                  Handshake
//   in_ch     sink       line_offset, left_angle, right_angle     valid/ready
//   out_ch    source     left_drive, right_drive                  valid/ready
//   cfg       write      cfg_index, cfg_data                      cfg_we
//
// An item is accepted only once the previous one is finished: nine gain
// products run one after another on the single shared multiplier.
// Reset is synchronous; there is no clearing pass.
// A finished result waits in the output register while the next item is
// accepted; the final step of that item holds until the register is free.
// ----------------------------------------------------------------------------
module cascade_pid_differential_drive_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  cpd_pkg::gain_t                cfg_data,
  cpd_in_if.sink                        in_ch,
  cpd_out_if.source                     out_ch
);
  import cpd_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  cpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cpd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .line_offset (in_ch.line_offset),
    .left_angle  (in_ch.left_angle),
    .right_angle (in_ch.right_angle),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .left_drive  (out_ch.left_drive),
    .right_drive (out_ch.right_drive)
  );

endmodule

// ===== rtl/core/cpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cascade PID differential drive: controller
// Sequences the outer loop and the two wheel loops through the shared
// multiplier, one step per state.
// ----------------------------------------------------------------------------
module cpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpd_pkg::status_t  status,
  output cpd_pkg::cmd_t     cmd
);
  import cpd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_PRE;
      ST_PRE:  state_next = ST_OA;
      ST_OA:   state_next = ST_OB;
      ST_OB:   state_next = ST_OC;
      ST_OC:   state_next = ST_OD;
      ST_OD:   state_next = ST_LA;
      ST_LA:   state_next = ST_LB;
      ST_LB:   state_next = ST_LC;
      ST_LC:   state_next = ST_LD;
      ST_LD:   state_next = ST_RA;
      ST_RA:   state_next = ST_RB;
      ST_RB:   state_next = ST_RC;
      ST_RC:   state_next = ST_RD;
      ST_RD:   if (!status.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    cmd.load  = in_valid && (state == ST_IDLE);
    cmd.phase = PH_IDLE;
    cmd.loop  = LOOP_OUTER;
    unique case (state)
      ST_IDLE: cmd.phase = PH_IDLE;
      ST_PRE:  cmd.phase = PH_PRE;
      ST_OA:   cmd.phase = PH_A;
      ST_OB:   cmd.phase = PH_B;
      ST_OC:   cmd.phase = PH_C;
      ST_OD:   cmd.phase = PH_D;
      ST_LA: begin
        cmd.phase = PH_A;
        cmd.loop  = LOOP_LEFT;
      end
      ST_LB: begin
        cmd.phase = PH_B;
        cmd.loop  = LOOP_LEFT;
      end
      ST_LC: begin
        cmd.phase = PH_C;
        cmd.loop  = LOOP_LEFT;
      end
      ST_LD: begin
        cmd.phase = PH_D;
        cmd.loop  = LOOP_LEFT;
      end
      ST_RA: begin
        cmd.phase = PH_A;
        cmd.loop  = LOOP_RIGHT;
      end
      ST_RB: begin
        cmd.phase = PH_B;
        cmd.loop  = LOOP_RIGHT;
      end
      ST_RC: begin
        cmd.phase = PH_C;
        cmd.loop  = LOOP_RIGHT;
      end
      ST_RD: begin
        cmd.phase = PH_D;
        cmd.loop  = LOOP_RIGHT;
      end
      default: cmd.phase = PH_IDLE;
    endcase
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_PRE)
    else $error("accepted item did not start the sequence");

  a_hold_final: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD && status.out_busy) |=> state == ST_RD)
    else $error("final step left while the output register was occupied");

  a_idle_no_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> cmd.phase == PH_IDLE)
    else $error("datapath step issued while idle");

endmodule

// ===== rtl/core/cpd_dp.sv =====
// ----------------------------------------------------------------------------
// Cascade PID differential drive: datapath
// Configuration registers, loop state, one shared gain multiplier and the
// output register.
// ----------------------------------------------------------------------------
module cpd_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  cpd_pkg::gain_t                     cfg_data,
  input  cpd_pkg::cmd_t                      cmd,
  output cpd_pkg::status_t                   status,
  input  cpd_pkg::q_t                        line_offset,
  input  cpd_pkg::q_t                        left_angle,
  input  cpd_pkg::q_t                        right_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cpd_pkg::gain_t                     left_drive,
  output cpd_pkg::gain_t                     right_drive
);
  import cpd_pkg::*;

  gain_t pos_kp, pos_ki_dt, pos_kd_inv_dt;
  gain_t vel_kp, vel_ki_dt, vel_kd_inv_dt;
  gain_t base_velocity, vel_limit;

  q_t offset_r, la_r, ra_r;
  q_t left_prev_angle, right_prev_angle;
  q_t lspeed, rspeed;
  q_t err [3];
  q_t prev_err [3];
  q_t integ [3];
  q_t dif, mres;
  logic signed [33:0] acc;
  gain_t ldrv;

  q_t                 e_cur;
  gain_t              kp_sel, ki_sel, kd_sel;
  gain_t              mul_gain;
  q_t                 mul_op;
  logic signed [63:0] prod;
  q_t                 mul_q;
  q_t                 dif_next;
  logic signed [63:0] int_sum;
  q_t                 int_new;
  q_t                 pid_out;
  q_t                 e_outer;
  q_t                 lspeed_next, rspeed_next;
  gain_t              lset, rset;
  q_t                 err_l, err_r;
  gain_t              drive;

  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_kp        <= '0;
      pos_ki_dt     <= '0;
      pos_kd_inv_dt <= '0;
      vel_kp        <= '0;
      vel_ki_dt     <= '0;
      vel_kd_inv_dt <= '0;
      base_velocity <= BASE_VELOCITY_RESET;
      vel_limit     <= VEL_LIMIT_RESET;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      unique case (reg_idx_t'(cfg_index[2:0]))
        REG_POS_KP:        pos_kp        <= cfg_data;
        REG_POS_KI_DT:     pos_ki_dt     <= cfg_data;
        REG_POS_KD_INV_DT: pos_kd_inv_dt <= cfg_data;
        REG_VEL_KP:        vel_kp        <= cfg_data;
        REG_VEL_KI_DT:     vel_ki_dt     <= cfg_data;
        REG_VEL_KD_INV_DT: vel_kd_inv_dt <= cfg_data;
        REG_BASE_VELOCITY: base_velocity <= cfg_data;
        REG_VEL_LIMIT:     vel_limit     <= cfg_data;
        default:           pos_kp        <= pos_kp;
      endcase
    end
  end

  always_comb begin
    e_cur = err[cmd.loop];
    if (cmd.loop == LOOP_OUTER) begin
      kp_sel = pos_kp;
      ki_sel = pos_ki_dt;
      kd_sel = pos_kd_inv_dt;
    end else begin
      kp_sel = vel_kp;
      ki_sel = vel_ki_dt;
      kd_sel = vel_kd_inv_dt;
    end
    unique case (cmd.phase)
      PH_A: begin
        mul_gain = ki_sel;
        mul_op   = e_cur;
      end
      PH_B: begin
        mul_gain = kd_sel;
        mul_op   = dif;
      end
      default: begin
        mul_gain = kp_sel;
        mul_op   = e_cur;
      end
    endcase
  end

  assign prod     = $signed({1'b0, mul_gain}) * mul_op;
  assign mul_q    = sat32(prod >>> 16);
  assign dif_next = sat32(sx64(e_cur) - sx64(prev_err[cmd.loop]));
  assign int_sum  = sx64(integ[cmd.loop]) + sx64(mres);
  assign pid_out  = sat32({{30{acc[33]}}, acc} + sx64(mres));
  assign e_outer  = sat32(sx64(TARGET_OFFSET) - sx64(offset_r));

  assign lspeed_next = sat32((sx64(la_r) - sx64(left_prev_angle)) * 64'(TICKS_PER_SECOND));
  assign rspeed_next = sat32((sx64(ra_r) - sx64(right_prev_angle)) * 64'(TICKS_PER_SECOND));

  always_comb begin
    if (int_sum > sx64(INTEGRAL_BOUND)) begin
      int_new = INTEGRAL_BOUND;
    end else if (int_sum < -sx64(INTEGRAL_BOUND)) begin
      int_new = -INTEGRAL_BOUND;
    end else begin
      int_new = int_sum[31:0];
    end
  end

  always_comb begin
    if (pid_out >= 32'sd0) begin
      lset = clamp_vel($signed({33'b0, base_velocity}) - sx64(pid_out), vel_limit);
    end else begin
      lset = base_velocity;
    end
    if (pid_out > 32'sd0) begin
      rset = base_velocity;
    end else begin
      rset = clamp_vel($signed({33'b0, base_velocity}) + sx64(pid_out), vel_limit);
    end
  end

  assign err_l = sat32($signed({33'b0, lset}) - sx64(lspeed));
  assign err_r = sat32($signed({33'b0, rset}) - sx64(rspeed));
  assign drive = clamp_vel(sx64(pid_out), vel_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev_angle  <= '0;
      right_prev_angle <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_err[i] <= '0;
        integ[i]    <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.phase == PH_PRE) begin
        left_prev_angle  <= la_r;
        right_prev_angle <= ra_r;
      end
      if (cmd.phase == PH_B) begin
        integ[cmd.loop]    <= int_new;
        prev_err[cmd.loop] <= e_cur;
      end
      if (cmd.phase == PH_D && cmd.loop == LOOP_RIGHT && !status.out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      offset_r <= line_offset;
      la_r     <= left_angle;
      ra_r     <= right_angle;
    end
    unique case (cmd.phase)
      PH_IDLE: begin
      end
      PH_PRE: begin
        lspeed          <= lspeed_next;
        rspeed          <= rspeed_next;
        err[LOOP_OUTER] <= e_outer;
      end
      PH_A: begin
        mres <= mul_q;
        dif  <= dif_next;
      end
      PH_B: begin
        mres <= mul_q;
        acc  <= {{2{int_new[31]}}, int_new};
      end
      PH_C: begin
        mres <= mul_q;
        acc  <= acc + {{2{mres[31]}}, mres};
      end
      PH_D: begin
        unique case (cmd.loop)
          LOOP_OUTER: begin
            err[LOOP_LEFT]  <= err_l;
            err[LOOP_RIGHT] <= err_r;
          end
          LOOP_LEFT: ldrv <= drive;
          LOOP_RIGHT: begin
            if (!status.out_busy) begin
              left_drive  <= ldrv;
              right_drive <= drive;
            end
          end
          default: ldrv <= ldrv;
        endcase
      end
      default: begin
      end
    endcase
  end

  a_out_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.phase == PH_D && cmd.loop == LOOP_RIGHT))
    else $error("result presented without the final step");

  a_outer_bound: assert property (@(posedge clk) disable iff (rst)
    (integ[LOOP_OUTER] <= INTEGRAL_BOUND) && (integ[LOOP_OUTER] >= -INTEGRAL_BOUND))
    else $error("outer integral out of bounds");

  a_wheel_bound: assert property (@(posedge clk) disable iff (rst)
    (integ[LOOP_LEFT] <= INTEGRAL_BOUND) && (integ[LOOP_LEFT] >= -INTEGRAL_BOUND) &&
    (integ[LOOP_RIGHT] <= INTEGRAL_BOUND) && (integ[LOOP_RIGHT] >= -INTEGRAL_BOUND))
    else $error("wheel integral out of bounds");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the cascade PID differential drive
// Sends sensor items through the input channel and compares every drive item
// with a typed table value or a fixed-point model of the cascade kept here.
// A directed table comes first, then random phases with new gains, random
// gaps on both channels and one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import cpd_pkg::*;

  typedef struct packed {
    gain_t left_drive;
    gain_t right_drive;
  } drive_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_TICK
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    gain_t                value;
    q_t                   offset;
    q_t                   left;
    q_t                   right;
    logic                 typed;
    gain_t                want_left;
    gain_t                want_right;
  } plan_row_t;

  localparam int          RESET_CYCLES    = 6;
  localparam int          ITEM_CYCLES     = 14;
  localparam int          STALL_LIMIT     = 2000;
  localparam int          LONG_HOLD       = 400;
  localparam int          LONG_HOLD_AFTER = 150;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          PHASE_ITEMS     = 50;
  localparam int unsigned Q_ONE           = 65536;
  localparam int unsigned OFFSET_SPAN     = 1 << 17;
  localparam int unsigned STEP_SPAN       = 1 << 13;

  localparam longint Q_HI        = 64'sd2147483647;
  localparam longint Q_LO        = -64'sd2147483648;
  localparam longint INTEG_LIMIT = 655360;
  localparam longint LINE_TARGET = 0;
  localparam longint TICK_RATE   = 32;

  localparam q_t    ONE      = 32'sd65536;
  localparam q_t    Q_TOP    = 32'sh7FFFFFFF;
  localparam q_t    Q_BOTTOM = 32'sh80000000;
  localparam gain_t G_ONE    = 31'd65536;
  localparam gain_t G_TOP    = 31'h7FFFFFFF;

  localparam logic [CFG_IDX_W-1:0] IDX_PAST_END  = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] IDX_LAST_CODE = '1;

  localparam int PLAN_LEN = 48;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_TICK, '0, '0, '0, '0, '0, 1'b1, '0, '0},
    '{ROW_TICK, '0, '0, Q_TOP, Q_TOP, Q_BOTTOM, 1'b1, '0, '0},
    '{ROW_TICK, '0, '0, Q_BOTTOM, Q_BOTTOM, Q_TOP, 1'b1, '0, '0},
    '{ROW_TICK, '0, '0, -ONE, ONE, -ONE, 1'b1, '0, '0},
    '{ROW_WRITE, REG_POS_KP, G_ONE / 2, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KI_DT, 31'd4096, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KD_INV_DT, 31'd2048, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KP, G_ONE, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KI_DT, 31'd8192, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KD_INV_DT, 31'd1024, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_BASE_VELOCITY, G_ONE * 3, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_LIMIT, G_ONE * 8, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, ONE / 4, ONE / 8, ONE / 8, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, -ONE / 4, ONE / 4, ONE / 4, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, '0, ONE / 4, ONE / 4, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, ONE * 2, ONE / 2, ONE * 3 / 4, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, -ONE * 20, ONE, ONE, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, ONE * 20, ONE * 2, ONE * 2, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KP, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KI_DT, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KD_INV_DT, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KP, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KI_DT, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KD_INV_DT, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_BASE_VELOCITY, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_LIMIT, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, Q_TOP, Q_TOP, Q_BOTTOM, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, Q_BOTTOM, Q_BOTTOM, Q_TOP, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, Q_TOP, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KP, G_ONE, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KI_DT, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_POS_KD_INV_DT, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, IDX_PAST_END, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KP, G_ONE, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KI_DT, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_KD_INV_DT, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_BASE_VELOCITY, G_ONE * 12, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_LIMIT, G_ONE * 4, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, ONE, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, -ONE, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, ONE / 2, ONE / 16, -ONE / 16, 1'b0, '0, '0},
    '{ROW_WRITE, REG_VEL_LIMIT, '0, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, IDX_LAST_CODE, G_TOP, '0, '0, '0, 1'b0, '0, '0},
    '{ROW_TICK, '0, '0, ONE, ONE, -ONE, 1'b1, '0, '0},
    '{ROW_TICK, '0, '0, Q_BOTTOM, Q_TOP, Q_BOTTOM, 1'b1, '0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  gain_t                cfg_data;

  cpd_in_if  in_ch();
  cpd_out_if out_ch();

  cascade_pid_differential_drive_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gain_t  ctl_reg [NUM_REGS];
  q_t     held_error [3];
  q_t     held_integ [3];
  q_t     last_left_angle;
  q_t     last_right_angle;
  drive_t drive_queue [$];
  int     fail_count = 0;
  int     drives_checked = 0;
  int     quiet_cycles = 0;

  function automatic void clear_model();
    for (int r = 0; r < NUM_REGS; r++) begin
      ctl_reg[r] = '0;
    end
    ctl_reg[REG_BASE_VELOCITY] = 31'd65536;
    ctl_reg[REG_VEL_LIMIT]     = 31'd655360;
    for (int k = 0; k < 3; k++) begin
      held_error[k] = '0;
      held_integ[k] = '0;
    end
    last_left_angle  = '0;
    last_right_angle = '0;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic longint to_q(longint v);
    return clip(v, Q_LO, Q_HI);
  endfunction

  // Q16.16 product, rounded toward minus infinity.
  function automatic longint scale(gain_t g, longint x);
    longint p;
    p = longint'(g) * x;
    return to_q(p >>> 16);
  endfunction

  function automatic longint pid_update(loop_t ch, gain_t kp, gain_t ki, gain_t kd,
                                        longint set, longint cur);
    longint e;
    longint p_term;
    longint i_term;
    longint d_term;
    e      = to_q(set - cur);
    p_term = scale(kp, e);
    i_term = clip(longint'(held_integ[ch]) + scale(ki, e), -INTEG_LIMIT, INTEG_LIMIT);
    d_term = scale(kd, to_q(e - longint'(held_error[ch])));
    held_error[ch] = e[31:0];
    held_integ[ch] = i_term[31:0];
    return to_q(p_term + i_term + d_term);
  endfunction

  function automatic drive_t drive_for_tick(q_t off, q_t la, q_t ra);
    longint base;
    longint vmax;
    longint lspeed;
    longint rspeed;
    longint u;
    longint lset;
    longint rset;
    longint ldrv;
    longint rdrv;
    drive_t d;
    base   = longint'(ctl_reg[REG_BASE_VELOCITY]);
    vmax   = longint'(ctl_reg[REG_VEL_LIMIT]);
    lspeed = to_q((longint'(la) - longint'(last_left_angle)) * TICK_RATE);
    rspeed = to_q((longint'(ra) - longint'(last_right_angle)) * TICK_RATE);
    last_left_angle  = la;
    last_right_angle = ra;
    u = pid_update(LOOP_OUTER, ctl_reg[REG_POS_KP], ctl_reg[REG_POS_KI_DT],
                   ctl_reg[REG_POS_KD_INV_DT], LINE_TARGET, longint'(off));
    // Only the wheel on the inner side of the turn is slowed down.
    lset = (u >= 0) ? clip(base - u, 0, vmax) : base;
    rset = (u > 0) ? base : clip(base + u, 0, vmax);
    ldrv = clip(pid_update(LOOP_LEFT, ctl_reg[REG_VEL_KP], ctl_reg[REG_VEL_KI_DT],
                           ctl_reg[REG_VEL_KD_INV_DT], lset, lspeed), 0, vmax);
    rdrv = clip(pid_update(LOOP_RIGHT, ctl_reg[REG_VEL_KP], ctl_reg[REG_VEL_KI_DT],
                           ctl_reg[REG_VEL_KD_INV_DT], rset, rspeed), 0, vmax);
    d.left_drive  = ldrv[30:0];
    d.right_drive = rdrv[30:0];
    return d;
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return G_TOP;
      2, 3, 4, 5: return gain_t'($urandom_range(0, 2 * Q_ONE));
      6, 7, 8: return gain_t'($urandom_range(0, Q_ONE / 8));
      default: return gain_t'($urandom());
    endcase
  endfunction

  function automatic gain_t pick_speed(int unsigned top);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return G_TOP;
      default: return gain_t'($urandom_range(0, top * Q_ONE));
    endcase
  endfunction

  function automatic gain_t choose_setting(int r, bit extreme);
    if (extreme) begin
      return G_TOP;
    end else if (r == REG_BASE_VELOCITY) begin
      return pick_speed(8);
    end else if (r == REG_VEL_LIMIT) begin
      return pick_speed(16);
    end
    return pick_gain();
  endfunction

  function automatic q_t pick_edge();
    case ($urandom_range(0, 3))
      0: return Q_TOP;
      1: return Q_BOTTOM;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    if (calm) begin
      return 0;
    end
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
      18, 19: return $urandom_range(8, 40);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  task automatic await_idle();
    while (drive_queue.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, gain_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx < NUM_REGS) begin
      ctl_reg[idx[2:0]] = value;
    end
  endtask

  task automatic send_tick(q_t off, q_t la, q_t ra, bit typed, gain_t wl, gain_t wr,
                           int unsigned gap);
    drive_t want;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.line_offset <= off;
    in_ch.left_angle  <= la;
    in_ch.right_angle <= ra;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    want = drive_for_tick(off, la, ra);
    if (typed) begin
      want.left_drive  = wl;
      want.right_drive = wr;
    end
    drive_queue.push_back(want);
  endtask

  initial begin : stimulus
    q_t off;
    q_t la;
    q_t ra;
    bit writing;
    bit calm;
    writing = 1'b0;
    la = '0;
    ra = '0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.line_offset <= '0;
    in_ch.left_angle  <= '0;
    in_ch.right_angle <= '0;
    clear_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        if (!writing) begin
          in_ch.valid <= 1'b0;
          await_idle();
          writing = 1'b1;
        end
        set_reg(plan[r].idx, plan[r].value);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_tick(plan[r].offset, plan[r].left, plan[r].right, plan[r].typed,
                  plan[r].want_left, plan[r].want_right, pick_gap(1'b0));
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_ch.valid <= 1'b0;
      await_idle();
      for (int r = 0; r < NUM_REGS; r++) begin
        set_reg(CFG_IDX_W'(r), choose_setting(r, ph == 0));
      end
      if ($urandom_range(0, 2) == 0) begin
        set_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                gain_t'($urandom()));
      end
      cfg_we <= 1'b0;
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          8: begin
            off = $urandom();
            la  = $urandom();
            ra  = $urandom();
          end
          9: begin
            off = pick_edge();
            la  = pick_edge();
            ra  = pick_edge();
          end
          default: begin
            off = $urandom_range(0, 2 * OFFSET_SPAN) - OFFSET_SPAN;
            la  = la + ($urandom_range(0, 2 * STEP_SPAN) - STEP_SPAN);
            ra  = ra + ($urandom_range(0, 2 * STEP_SPAN) - STEP_SPAN);
          end
        endcase
        send_tick(off, la, ra, 1'b0, '0, '0, pick_gap(calm));
      end
    end

    in_ch.valid <= 1'b0;
    await_idle();
    repeat (ITEM_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS cascade_pid_differential_drive_top");
    end else begin
      $display("FAIL cascade_pid_differential_drive_top");
    end
    $finish;
  end

  // Drive-side back-pressure, including one long hold once the run is well
  // under way so that the block fills up and stalls its input.
  initial begin : drain
    int unsigned span;
    bit          held_long;
    held_long = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (!held_long && drives_checked >= LONG_HOLD_AFTER) begin
        held_long = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(1, 30);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_ch.ready <= 1'b1;
            repeat (span) @(posedge clk);
          end
          4, 5, 6: begin
            repeat (span) begin
              out_ch.ready <= 1'($urandom_range(0, 1));
              @(posedge clk);
            end
          end
          7, 8: begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
          end
          default: begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(8, 40)) @(posedge clk);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : drive_check
    drive_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (drive_queue.size() == 0) begin
        $error("unexpected item: left_drive %0d, right_drive %0d",
               out_ch.left_drive, out_ch.right_drive);
        fail_count++;
      end else begin
        want = drive_queue.pop_front();
        if (out_ch.left_drive !== want.left_drive) begin
          $error("left_drive: expected %0d, got %0d", want.left_drive, out_ch.left_drive);
          fail_count++;
        end
        if (out_ch.right_drive !== want.right_drive) begin
          $error("right_drive: expected %0d, got %0d", want.right_drive,
                 out_ch.right_drive);
          fail_count++;
        end
      end
      drives_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL cascade_pid_differential_drive_top");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/cpd_pkg.sv
rtl/core/cpd_if.sv
rtl/core/cpd_ctrl.sv
rtl/core/cpd_dp.sv
rtl/core/cascade_pid_differential_drive_top.sv
test/testbench.sv
